// ----- hdl/cfs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV field splitter package
// Shared types, codes and constants of the CSV field splitter.
// ----------------------------------------------------------------------------
package cfs_pkg;

  localparam int unsigned BLANK_DEPTH_DEFAULT = 16;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  localparam logic [7:0] DELIMITER_RESET = 8'd44;
  localparam logic [7:0] ENCLOSURE_RESET = 8'd34;

  typedef enum logic {
    CFG_DELIMITER = 1'b0,
    CFG_ENCLOSURE = 1'b1
  } cfs_cfg_idx_e;

  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_EOL  = 1'b1
  } cfs_action_e;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_END     = 2'd1,
    KIND_ERROR   = 2'd2,
    KIND_ABANDON = 2'd3
  } cfs_kind_e;

  typedef enum logic [1:0] {
    ERR_DELIM    = 2'd0,
    ERR_UNCLOSED = 2'd1,
    ERR_OVERFLOW = 2'd2
  } cfs_err_e;

  typedef struct packed {
    cfs_action_e action;
    logic [7:0]  in_byte;
  } cfs_in_t;

  typedef struct packed {
    cfs_kind_e   kind;
    logic [7:0]  out_byte;
    logic [15:0] field_number;
    logic [15:0] column;
    cfs_err_e    error_code;
    logic        line_last;
  } cfs_out_t;

  function automatic logic [15:0] sat_inc16(input logic [15:0] x);
    sat_inc16 = (x == 16'hFFFF) ? x : x + 16'd1;
  endfunction

endpackage

// ----- hdl/csv_field_splitter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV field splitter
// Splits a stream of line bytes into fields on a configurable delimiter,
// with quoted fields, trailing blank removal and error reporting.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  in        input      in_valid_i/in_stall_o  cfs_in_t (action, in_byte)
//  out       output     out_valid_o/out_stall_i cfs_out_t (kind .. line_last)
//  cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
//  The front end takes one item per cycle while the command queue is not
//  full, and issues at most one command. The back end sends one result per
//  cycle unless the output stalls; held blanks go out before the content
//  byte that follows them, and while they drain the two-entry command queue
//  fills and stalls input. Reset is asynchronous and active low; the
//  configuration port is always ready.
// ----------------------------------------------------------------------------
module csv_field_splitter_top #(
  parameter int unsigned BLANK_DEPTH = cfs_pkg::BLANK_DEPTH_DEFAULT,
  parameter int unsigned QUEUE_DEPTH = cfs_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cfs_pkg::cfs_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cfs_pkg::cfs_out_t out_item_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [7:0]        cfg_data_i
);
  import cfs_pkg::*;

  localparam int unsigned CntW = $clog2(BLANK_DEPTH + 1);
  localparam int unsigned CmdW = $bits(cfs_out_t) + CntW + BLANK_DEPTH;

  logic                   fire, push, pop, q_empty, q_full;
  cfs_out_t               f_rec, b_rec;
  logic [CntW-1:0]        f_cnt, b_cnt;
  logic [BLANK_DEPTH-1:0] f_kinds, b_kinds;
  logic [CmdW-1:0]        q_head;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;
  assign fire        = in_valid_i && !q_full;

  cfs_front #(
    .BLANK_DEPTH(BLANK_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_fire_i (fire),
    .item_i      (in_item_i),
    .cmd_push_o  (push),
    .cmd_rec_o   (f_rec),
    .cmd_cnt_o   (f_cnt),
    .cmd_kinds_o (f_kinds)
  );

  cfs_queue #(
    .WIDTH(CmdW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({f_rec, f_cnt, f_kinds}),
    .pop_i       (pop),
    .head_o      (q_head),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  assign {b_rec, b_cnt, b_kinds} = q_head;

  cfs_back #(
    .BLANK_DEPTH(BLANK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_rec_i     (b_rec),
    .q_cnt_i     (b_cnt),
    .q_kinds_i   (b_kinds),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// ----- hdl/cfs_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV field splitter front end
// Holds the parse state, classifies each line byte and issues at most one
// command (a result record plus the held blanks to flush before it) per item.
// ----------------------------------------------------------------------------
module cfs_front #(
  parameter int unsigned BLANK_DEPTH = cfs_pkg::BLANK_DEPTH_DEFAULT,
  parameter int unsigned CntW = $clog2(BLANK_DEPTH + 1),
  parameter int unsigned IdxW = (BLANK_DEPTH > 1) ? $clog2(BLANK_DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic             cfg_index_i,
  input  logic [7:0]       cfg_data_i,
  input  logic             item_fire_i,
  input  cfs_pkg::cfs_in_t item_i,
  output logic             cmd_push_o,
  output cfs_pkg::cfs_out_t cmd_rec_o,
  output logic [CntW-1:0]  cmd_cnt_o,
  output logic [BLANK_DEPTH-1:0] cmd_kinds_o
);
  import cfs_pkg::*;

  typedef enum logic [2:0] {
    MODE_START,
    MODE_PLAIN,
    MODE_QUOTED,
    MODE_QUOTE_SEEN,
    MODE_AFTER_QUOTE,
    MODE_DISCARD
  } mode_e;

  localparam logic [CntW-1:0] DepthCnt = CntW'(BLANK_DEPTH);

  mode_e                  mode_q, mode_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [BLANK_DEPTH-1:0] kinds_q, kinds_d;
  logic [15:0]            field_q, field_d;
  logic [15:0]            col_q, col_d;
  logic [7:0]             delim_q, encl_q;

  logic [7:0]      c;
  logic            is_blank, is_skip;
  logic [CntW-1:0] eff_cnt;

  assign c        = item_i.in_byte;
  assign is_blank = (c == CHAR_SPACE) || (c == CHAR_TAB);
  assign is_skip  = is_blank || (c == CHAR_CR) || (c == CHAR_LF);
  // A field start always begins with an empty blank buffer.
  assign eff_cnt  = (mode_q == MODE_START) ? '0 : cnt_q;

  always_comb begin
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    kinds_d = kinds_q;
    field_d = field_q;
    col_d   = col_q;

    cmd_push_o = 1'b0;
    cmd_cnt_o  = '0;
    cmd_kinds_o = kinds_q;
    cmd_rec_o.kind         = KIND_BYTE;
    cmd_rec_o.out_byte     = 8'd0;
    cmd_rec_o.field_number = field_q;
    cmd_rec_o.column       = col_q;
    cmd_rec_o.error_code   = ERR_DELIM;
    cmd_rec_o.line_last    = 1'b0;

    if (item_fire_i) begin
      if (item_i.action == ACT_EOL) begin
        cmd_push_o = 1'b1;
        cmd_rec_o.line_last = 1'b1;
        unique case (mode_q)
          MODE_QUOTED: begin
            cmd_rec_o.kind       = KIND_ERROR;
            cmd_rec_o.error_code = ERR_UNCLOSED;
          end
          MODE_DISCARD: cmd_rec_o.kind = KIND_ABANDON;
          default:      cmd_rec_o.kind = KIND_END;
        endcase
        mode_d  = MODE_START;
        cnt_d   = '0;
        field_d = '0;
        col_d   = '0;
      end else begin
        col_d = sat_inc16(col_q);
        unique case (mode_q)
          MODE_START, MODE_PLAIN: begin
            if ((mode_q == MODE_START) && (c == encl_q)) begin
              mode_d = MODE_QUOTED;
            end else if (c == delim_q) begin
              cmd_push_o     = 1'b1;
              cmd_rec_o.kind = KIND_END;
              field_d        = sat_inc16(field_q);
              cnt_d          = '0;
              mode_d         = MODE_START;
            end else if (is_blank) begin
              mode_d = MODE_PLAIN;
              if (eff_cnt < DepthCnt) begin
                kinds_d[eff_cnt[IdxW-1:0]] = (c == CHAR_TAB);
                cnt_d = eff_cnt + CntW'(1);
              end else begin
                cnt_d                = '0;
                cmd_push_o           = 1'b1;
                cmd_rec_o.kind       = KIND_ERROR;
                cmd_rec_o.error_code = ERR_OVERFLOW;
                mode_d               = MODE_DISCARD;
              end
            end else begin
              // Content byte: held blanks go out first, then the byte.
              mode_d             = MODE_PLAIN;
              cmd_push_o         = 1'b1;
              cmd_cnt_o          = eff_cnt;
              cmd_rec_o.out_byte = c;
              cnt_d              = '0;
            end
          end
          MODE_QUOTED: begin
            if (c == encl_q) begin
              mode_d = MODE_QUOTE_SEEN;
            end else begin
              cmd_push_o         = 1'b1;
              cmd_rec_o.out_byte = c;
            end
          end
          MODE_QUOTE_SEEN, MODE_AFTER_QUOTE: begin
            if ((mode_q == MODE_QUOTE_SEEN) && (c == encl_q)) begin
              cmd_push_o         = 1'b1;
              cmd_rec_o.out_byte = c;
              mode_d             = MODE_QUOTED;
            end else if (c == delim_q) begin
              cmd_push_o     = 1'b1;
              cmd_rec_o.kind = KIND_END;
              field_d        = sat_inc16(field_q);
              mode_d         = MODE_START;
            end else if (is_skip) begin
              mode_d = MODE_AFTER_QUOTE;
            end else begin
              cmd_push_o           = 1'b1;
              cmd_rec_o.kind       = KIND_ERROR;
              cmd_rec_o.error_code = ERR_DELIM;
              mode_d               = MODE_DISCARD;
            end
          end
          default: mode_d = MODE_DISCARD;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_START;
      cnt_q   <= '0;
      field_q <= '0;
      col_q   <= '0;
      delim_q <= DELIMITER_RESET;
      encl_q  <= ENCLOSURE_RESET;
    end else begin
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      field_q <= field_d;
      col_q   <= col_d;
      if (cfg_valid_i) begin
        unique case (cfs_cfg_idx_e'(cfg_index_i))
          CFG_DELIMITER: delim_q <= cfg_data_i;
          CFG_ENCLOSURE: encl_q  <= cfg_data_i;
        endcase
      end
    end
  end

  // Blank kinds are only read below the held count.
  always_ff @(posedge clk_i) begin
    kinds_q <= kinds_d;
  end

endmodule

// ----- hdl/cfs_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV field splitter command queue
// Small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module cfs_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = cfs_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] head_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FillW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [FillW-1:0] FullFill = FillW'(DEPTH);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [FillW-1:0] fill_q;

  assign empty_o = (fill_q == '0);
  assign full_o  = (fill_q == FullFill);
  assign head_o  = store_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + FillW'(1);
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - FillW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ----- hdl/cfs_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV field splitter back end
// Expands each command into its held blank bytes and its record, and drives
// the registered result channel.
// ----------------------------------------------------------------------------
module cfs_back #(
  parameter int unsigned BLANK_DEPTH = cfs_pkg::BLANK_DEPTH_DEFAULT,
  parameter int unsigned CntW = $clog2(BLANK_DEPTH + 1),
  parameter int unsigned IdxW = (BLANK_DEPTH > 1) ? $clog2(BLANK_DEPTH) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_empty_i,
  input  cfs_pkg::cfs_out_t      q_rec_i,
  input  logic [CntW-1:0]        q_cnt_i,
  input  logic [BLANK_DEPTH-1:0] q_kinds_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  output cfs_pkg::cfs_out_t      out_item_o,
  input  logic                   out_stall_i
);
  import cfs_pkg::*;

  logic                   cur_valid_q, cur_valid_d;
  cfs_out_t               cur_rec_q;
  logic [CntW-1:0]        cur_cnt_q;
  logic [BLANK_DEPTH-1:0] cur_kinds_q;
  logic [CntW-1:0]        idx_q, idx_d;
  logic                   out_valid_q, out_valid_d;
  cfs_out_t               out_q, out_d;

  cfs_out_t               src_rec;
  logic [CntW-1:0]        src_cnt, src_idx;
  logic [BLANK_DEPTH-1:0] src_kinds;
  logic                   src_valid, load, take_blank;

  // Work on the held command, or straight from the queue head when none.
  assign src_rec   = cur_valid_q ? cur_rec_q   : q_rec_i;
  assign src_cnt   = cur_valid_q ? cur_cnt_q   : q_cnt_i;
  assign src_kinds = cur_valid_q ? cur_kinds_q : q_kinds_i;
  assign src_idx   = cur_valid_q ? idx_q       : '0;
  assign src_valid = cur_valid_q || !q_empty_i;

  assign load       = (!out_valid_q || !out_stall_i) && src_valid;
  assign take_blank = src_idx < src_cnt;
  assign q_pop_o    = load && !cur_valid_q;

  always_comb begin
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_d       = src_rec;
      if (take_blank) begin
        out_d.kind       = KIND_BYTE;
        out_d.out_byte   = src_kinds[src_idx[IdxW-1:0]] ? CHAR_TAB : CHAR_SPACE;
        out_d.error_code = ERR_DELIM;
        out_d.line_last  = 1'b0;
        cur_valid_d      = 1'b1;
        idx_d            = src_idx + CntW'(1);
      end else begin
        cur_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (q_pop_o) begin
      cur_rec_q   <= q_rec_i;
      cur_cnt_q   <= q_cnt_i;
      cur_kinds_q <= q_kinds_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
